@@ rtl/rfd_pkg.sv @@
// Shared constants and types for the frame deframer.
`timescale 1ns / 1ps
package rfd_pkg;

	localparam logic [7:0] FRAME_HEADER  = 8'hA0;
	localparam int         MIN_TOTAL     = 5;
	localparam int         LEN_OVERHEAD  = 2;
	localparam int         ADDR_POS      = 2;
	localparam int         CMD_POS       = 3;
	localparam int         PAYLOAD_START = 4;
	// Len + overhead can reach 257 before the range check
	localparam int         LEN_TOTAL_W   = 9;
	localparam int         OUT_LEN_W     = 6;

	typedef struct packed {
		logic [7:0] address;
		logic [7:0] command;
		logic       checksum_ok;
	} frame_meta_t;

endpackage

@@ rtl/reader_frame_deframer_unit.sv @@
// Top level of the length-prefixed frame deframer.
`timescale 1ns / 1ps
// Takes one received byte per cycle while collecting a frame (header 0xA0, Len,
// address, command, payload, checksum; Len+2 bytes in all). Bytes are kept in a
// MAX_FRAME-entry buffer with a registered read. When the checksum byte lands the
// block stops taking bytes and reads the payload back through the buffer's single
// read port, one result per cycle when the output is not stalled; rx_ready rises
// again once the last read has moved into the result register. A frame with an
// empty payload yields one result with has_payload low; bad lengths are dropped
// silently; a bad checksum still yields the frame with checksum_ok low. A header
// byte inside a frame is plain data.
module reader_frame_deframer_unit #(
	parameter int MAX_FRAME = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [7:0]                     rx_byte,
	input  logic                           rx_valid,
	output logic                           rx_ready,
	output logic [7:0]                     frame_address,
	output logic [7:0]                     frame_command,
	output logic [rfd_pkg::OUT_LEN_W-1:0]  payload_length,
	output logic                           has_payload,
	output logic [7:0]                     payload_byte,
	output logic [rfd_pkg::OUT_LEN_W-1:0]  payload_index,
	output logic                           checksum_ok,
	output logic                           last,
	output logic                           result_valid,
	input  logic                           result_ready
);

	localparam int AW = $clog2(MAX_FRAME);
	localparam int CW = $clog2(MAX_FRAME + 1);

	logic                 emit_busy;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [7:0]           wr_data;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [7:0]           rd_data;
	logic                 start;
	rfd_pkg::frame_meta_t meta;
	logic [CW-1:0]        plen;

	rfd_rx_ctrl #(
		.MAX_FRAME(MAX_FRAME)
	) u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.emit_busy(emit_busy),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.start    (start),
		.meta     (meta),
		.plen     (plen)
	);

	rfd_frame_ram #(
		.DEPTH(MAX_FRAME)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	rfd_emit #(
		.MAX_FRAME(MAX_FRAME)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.meta          (meta),
		.plen          (plen),
		.busy          (emit_busy),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.frame_address (frame_address),
		.frame_command (frame_command),
		.payload_length(payload_length),
		.has_payload   (has_payload),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.checksum_ok   (checksum_ok),
		.last          (last),
		.result_valid  (result_valid),
		.result_ready  (result_ready)
	);

endmodule

@@ rtl/rfd_frame_ram.sv @@
// Frame byte buffer: one write port, one enabled read port with registered data.
`timescale 1ns / 1ps
module rfd_frame_ram #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while the reader stalls
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/rfd_rx_ctrl.sv @@
// Receive side: header hunt, length check, buffering and checksum.
`timescale 1ns / 1ps
module rfd_rx_ctrl #(
	parameter int MAX_FRAME = 64,
	localparam int AW = $clog2(MAX_FRAME),
	localparam int CW = $clog2(MAX_FRAME + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           rx_byte,
	input  logic                 rx_valid,
	output logic                 rx_ready,
	input  logic                 emit_busy,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [7:0]           wr_data,
	output logic                 start,
	output rfd_pkg::frame_meta_t meta,
	output logic [CW-1:0]        plen
);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] total_q;
	logic [7:0]    sum_q;
	logic [7:0]    addr_q;
	logic [7:0]    cmd_q;
	logic          ok_q;
	logic [CW-1:0] plen_q;

	logic                               accept;
	logic [CW-1:0]                      cnt_inc;
	logic [rfd_pkg::LEN_TOTAL_W-1:0]    len_total;
	logic                               len_bad;
	logic                               complete;
	logic [7:0]                         want;

	assign rx_ready  = !emit_busy;
	assign accept    = rx_valid && !emit_busy;
	assign cnt_inc   = cnt_q + CW'(1);
	assign len_total = {1'b0, rx_byte} + rfd_pkg::LEN_TOTAL_W'(rfd_pkg::LEN_OVERHEAD);
	assign len_bad   = (len_total < rfd_pkg::LEN_TOTAL_W'(rfd_pkg::MIN_TOTAL)) ||
	                   (len_total > rfd_pkg::LEN_TOTAL_W'(MAX_FRAME));
	// total_q is zero until the length byte is in
	assign complete  = (cnt_q != '0) && (total_q != '0) && (cnt_inc == total_q);
	assign want      = 8'(8'd0 - sum_q);

	assign wr_en   = accept && ((cnt_q != '0) || (rx_byte == rfd_pkg::FRAME_HEADER));
	assign wr_addr = cnt_q[AW-1:0];
	assign wr_data = rx_byte;
	assign start   = accept && complete;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			total_q <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			if (cnt_q == '0) begin
				if (rx_byte == rfd_pkg::FRAME_HEADER) begin
					cnt_q   <= CW'(1);
					total_q <= '0;
					sum_q   <= rx_byte;
				end
			end else if (cnt_q == CW'(1)) begin
				if (len_bad) begin
					cnt_q   <= '0;
					total_q <= '0;
					sum_q   <= '0;
				end else begin
					cnt_q   <= cnt_inc;
					total_q <= CW'(len_total);
					sum_q   <= sum_q + rx_byte;
				end
			end else if (complete || (cnt_inc == CW'(MAX_FRAME))) begin
				cnt_q   <= '0;
				total_q <= '0;
				sum_q   <= '0;
			end else begin
				cnt_q <= cnt_inc;
				sum_q <= sum_q + rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cnt_q == CW'(rfd_pkg::ADDR_POS))) begin
			addr_q <= rx_byte;
		end
		if (accept && (cnt_q == CW'(rfd_pkg::CMD_POS))) begin
			cmd_q <= rx_byte;
		end
		if (start) begin
			ok_q   <= (want == rx_byte);
			plen_q <= total_q - CW'(rfd_pkg::MIN_TOTAL);
		end
	end

	assign meta.address     = addr_q;
	assign meta.command     = cmd_q;
	assign meta.checksum_ok = ok_q;
	assign plen             = plen_q;

endmodule

@@ rtl/rfd_emit.sv @@
// Result side: walks the payload in the buffer and drives the result registers.
`timescale 1ns / 1ps
module rfd_emit #(
	parameter int MAX_FRAME = 64,
	localparam int AW = $clog2(MAX_FRAME),
	localparam int CW = $clog2(MAX_FRAME + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  rfd_pkg::frame_meta_t           meta,
	input  logic [CW-1:0]                  plen,
	output logic                           busy,
	output logic                           rd_en,
	output logic [AW-1:0]                  rd_addr,
	input  logic [7:0]                     rd_data,
	output logic [7:0]                     frame_address,
	output logic [7:0]                     frame_command,
	output logic [rfd_pkg::OUT_LEN_W-1:0]  payload_length,
	output logic                           has_payload,
	output logic [7:0]                     payload_byte,
	output logic [rfd_pkg::OUT_LEN_W-1:0]  payload_index,
	output logic                           checksum_ok,
	output logic                           last,
	output logic                           result_valid,
	input  logic                           result_ready
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic          state_q;
	logic [CW-1:0] k_q;
	logic          issued_all_q;
	logic          s1_valid_q;
	logic          out_valid_q;

	logic [rfd_pkg::OUT_LEN_W-1:0] idx_s1;
	logic                          last_s1;

	logic [CW-1:0] n_m1;
	logic          last_rd;
	logic          out_load;
	logic          issue;
	logic          nonempty;

	assign nonempty = (plen != '0);
	// an empty payload still yields one result
	assign n_m1     = nonempty ? (plen - CW'(1)) : '0;
	assign last_rd  = (k_q == n_m1);
	assign out_load = s1_valid_q && (!out_valid_q || result_ready);
	assign issue    = (state_q == ST_READ) && !issued_all_q && (!s1_valid_q || out_load);

	assign busy    = (state_q == ST_READ);
	assign rd_en   = issue;
	assign rd_addr = k_q[AW-1:0] + AW'(rfd_pkg::PAYLOAD_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			k_q          <= '0;
			issued_all_q <= 1'b0;
			s1_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q      <= ST_READ;
						k_q          <= '0;
						issued_all_q <= 1'b0;
					end
				end
				ST_READ: begin
					if (issue) begin
						k_q <= k_q + CW'(1);
						if (last_rd) begin
							issued_all_q <= 1'b1;
						end
					end
					// leave once the last read has moved into the result register
					if (issued_all_q && (!s1_valid_q || out_load)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			s1_valid_q  <= issue || (s1_valid_q && !out_load);
			out_valid_q <= out_load || (out_valid_q && !result_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= rfd_pkg::OUT_LEN_W'(k_q);
			last_s1 <= last_rd;
		end
		if (out_load) begin
			frame_address  <= meta.address;
			frame_command  <= meta.command;
			payload_length <= rfd_pkg::OUT_LEN_W'(plen);
			has_payload    <= nonempty;
			payload_byte   <= nonempty ? rd_data : 8'd0;
			payload_index  <= nonempty ? idx_s1 : '0;
			checksum_ok    <= meta.checksum_ok;
			last           <= last_s1;
		end
	end

	assign result_valid = out_valid_q;

endmodule
